// ===== rtl/core/lcdpu_pkg.sv =====
`timescale 1ns / 1ps

package lcdpu_pkg;

	localparam int PAL_DEPTH   = 256;
	localparam int PAL_WORDS   = PAL_DEPTH / 2;
	localparam int PAL_AW      = $clog2(PAL_WORDS);
	localparam int QUEUE_DEPTH = 4;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		KIND_FRAME  = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_PAL_WR = 2'd2,
		KIND_PAL_RD = 2'd3
	} kind_t;

	localparam logic [2:0] REG_DEPTH_CODE = 3'd0;
	localparam logic [2:0] REG_GREY_HIGH  = 3'd1;
	localparam logic [2:0] REG_BIG_ENDIAN = 3'd2;
	localparam logic [2:0] REG_MSB_FIRST  = 3'd3;

	typedef struct packed {
		logic [1:0] depth_code;
		logic       grey_from_high_bits;
		logic       big_endian_bytes;
		logic       msb_pixel_first;
	} cfg_t;

	// one queued request, with its row and first column already settled
	typedef struct packed {
		kind_t        kind;
		logic [6:0]   pidx;
		logic [31:0]  data;
		logic [7:0]   row;
		logic [7:0]   col_base;
	} job_t;

	// bit position of pixel 2k+second inside the framebuffer word
	function automatic logic [4:0] pixel_shift(logic [3:0] k, logic second, cfg_t cfg);
		logic [5:0] pnum;
		logic [8:0] prod;
		logic [8:0] bitpos;
		logic [4:0] bpp;
		logic [4:0] order;
		pnum   = 6'({k, second}) + 6'd1;
		prod   = 9'(pnum) << cfg.depth_code;
		bitpos = 9'd32 - prod;
		bpp    = 5'd1 << cfg.depth_code;
		order  = cfg.big_endian_bytes ? 5'd0 : 5'd24;
		if (!cfg.msb_pixel_first)
			order = order ^ (5'd8 - bpp);
		return bitpos[4:0] ^ order;
	endfunction

	function automatic logic [7:0] pixel_index(logic [31:0] data, logic [4:0] shamt,
			logic [1:0] depth_code);
		logic [31:0] shifted;
		logic [7:0]  mask;
		shifted = data >> shamt;
		unique case (depth_code)
			2'd0: mask = 8'h01;
			2'd1: mask = 8'h03;
			2'd2: mask = 8'h0F;
			default: mask = 8'hFF;
		endcase
		return shifted[7:0] & mask;
	endfunction

	function automatic logic [3:0] grey_of(logic [15:0] entry, logic high);
		return high ? entry[14:11] : entry[4:1];
	endfunction

endpackage

// ===== rtl/core/lcdpu_if.sv =====
`timescale 1ns / 1ps

interface lcdpu_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [6:0]  palette_word_index;
	logic [31:0] data_word;

	modport source(output valid, kind, palette_word_index, data_word, input ready);
	modport sink(input valid, kind, palette_word_index, data_word, output ready);
endinterface

interface lcdpu_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  pixel_pair;
	logic [7:0]  row_index;
	logic [7:0]  byte_column;
	logic [31:0] read_data;
	logic        last;

	modport source(output valid, pixel_pair, row_index, byte_column, read_data, last,
		input ready);
	modport sink(input valid, pixel_pair, row_index, byte_column, read_data, last,
		output ready);
endinterface

// ===== rtl/core/palette_lcd_pixel_unpacker_top.sv =====
`timescale 1ns / 1ps

// Palette LCD pixel unpacker. A request is taken whenever the four-entry
// request queue has room. Frame starts and palette writes give no result; a
// palette read gives one result; a pixel word gives 16 >> depth_code bytes,
// one per cycle while results are taken, so a pixel word holds the palette
// lookup until its last byte is issued. The lookup reads two palette entries
// per cycle while not stalled, through the two read ports of the palette
// memory. The first result of a request passes the palette read registers and
// the output register. The palette reads as zero until written; there is no
// clearing pass after reset.
module palette_lcd_pixel_unpacker_top #(
	parameter int ROWS    = 240,
	parameter int COLUMNS = 320
) (
	input  logic         clk,
	input  logic         arst_n,
	lcdpu_cmd_if.sink    cmd,
	lcdpu_res_if.source  res,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [1:0]   cfg_wdata
);
	import lcdpu_pkg::*;

	cfg_t cfg_q;
	logic push;
	job_t push_job;
	logic q_full;
	logic pop;
	logic head_valid;
	job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEPTH_CODE: cfg_q.depth_code          <= cfg_wdata;
				REG_GREY_HIGH:  cfg_q.grey_from_high_bits <= cfg_wdata[0];
				REG_BIG_ENDIAN: cfg_q.big_endian_bytes    <= cfg_wdata[0];
				REG_MSB_FIRST:  cfg_q.msb_pixel_first     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	lcdpu_front #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	lcdpu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	lcdpu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.res        (res)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("request pushed into full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.read_data != 32'h0) |->
			(res.pixel_pair == 8'h0 && res.row_index == 8'h0 && res.last))
		else $error("palette read result mixed with pixel fields");

endmodule

// ===== rtl/core/lcdpu_front.sv =====
`timescale 1ns / 1ps

module lcdpu_front #(
	parameter int ROWS    = 240,
	parameter int COLUMNS = 320
) (
	input  logic              clk,
	input  logic              arst_n,
	lcdpu_cmd_if.sink         cmd,
	input  lcdpu_pkg::cfg_t   cfg,
	input  logic              q_full,
	output logic              push,
	output lcdpu_pkg::job_t   push_job
);
	import lcdpu_pkg::*;

	localparam int WPR_UNIT = COLUMNS / 32;
	localparam int WIR_W    = $clog2(WPR_UNIT * 8);
	localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [ROW_W-1:0] ROW_TOP = ROW_W'(ROWS - 1);

	logic [ROW_W-1:0] row_q;
	logic [WIR_W-1:0] wir_q;
	logic [WIR_W:0]   wpr;
	logic [WIR_W:0]   wir_inc;
	logic [WIR_W+3:0] col_wide;
	logic             accept;
	kind_t            kind;

	assign cmd.ready = !q_full;
	assign accept    = cmd.valid && cmd.ready;
	assign kind      = kind_t'(cmd.kind);
	assign wpr       = (WIR_W + 1)'(WPR_UNIT) << cfg.depth_code;
	assign wir_inc   = {1'b0, wir_q} + (WIR_W + 1)'(1);
	assign col_wide  = (WIR_W + 4)'(wir_q) << (3'd4 - {1'b0, cfg.depth_code});

	assign push     = accept && (kind != KIND_FRAME);
	assign push_job = '{
		kind:     kind,
		pidx:     cmd.palette_word_index,
		data:     cmd.data_word,
		row:      8'(row_q),
		col_base: col_wide[7:0]
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= ROW_TOP;
			wir_q <= '0;
		end else if (accept) begin
			if (kind == KIND_FRAME) begin
				row_q <= ROW_TOP;
				wir_q <= '0;
			end else if (kind == KIND_PIXEL) begin
				if (wir_inc >= wpr) begin
					wir_q <= '0;
					row_q <= (row_q == '0) ? ROW_TOP : row_q - ROW_W'(1);
				end else begin
					wir_q <= wir_inc[WIR_W-1:0];
				end
			end
		end
	end

endmodule

// ===== rtl/core/lcdpu_queue.sv =====
`timescale 1ns / 1ps

module lcdpu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcdpu_pkg::job_t   push_job,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output lcdpu_pkg::job_t   head_job
);
	import lcdpu_pkg::*;

	job_t            q_mem [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QP_W:0]   count_q;

	assign full       = (count_q == (QP_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QP_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			if (push && !pop)
				count_q <= count_q + (QP_W + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QP_W + 1)'(1);
		end
	end

endmodule

// ===== rtl/core/lcdpu_back.sv =====
`timescale 1ns / 1ps

module lcdpu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lcdpu_pkg::cfg_t   cfg,
	input  logic              head_valid,
	input  lcdpu_pkg::job_t   head_job,
	output logic              pop,
	lcdpu_res_if.source       res
);
	import lcdpu_pkg::*;

	logic [31:0]          pal_mem [PAL_WORDS];
	logic [PAL_WORDS-1:0] pal_vld_q;

	logic [3:0]        k_q;
	logic [3:0]        k_last;
	logic              is_pix;
	logic              is_wr;
	logic              is_rd;
	logic              step_last;
	logic              issue;
	logic              out_free;
	logic              s1_free;
	logic [7:0]        idx_a;
	logic [7:0]        idx_b;
	logic [PAL_AW-1:0] addr_a;
	logic [PAL_AW-1:0] addr_b;

	logic        s1_valid_q;
	logic [31:0] rdata_a_s1;
	logic [31:0] rdata_b_s1;
	logic        vld_a_s1;
	logic        vld_b_s1;
	logic        half_a_s1;
	logic        half_b_s1;
	logic        is_rd_s1;
	logic [7:0]  row_s1;
	logic [7:0]  col_s1;
	logic        last_s1;

	logic [15:0] entry_a;
	logic [15:0] entry_b;

	logic        out_valid_q;
	logic [7:0]  pixel_pair_s2;
	logic [7:0]  row_index_s2;
	logic [7:0]  byte_column_s2;
	logic [31:0] read_data_s2;
	logic        last_s2;

	assign is_pix    = (head_job.kind == KIND_PIXEL);
	assign is_wr     = (head_job.kind == KIND_PAL_WR);
	assign is_rd     = (head_job.kind == KIND_PAL_RD);
	assign k_last    = 4'hF >> cfg.depth_code;
	assign step_last = !is_pix || (k_q == k_last);

	assign out_free = !out_valid_q || res.ready;
	assign s1_free  = !s1_valid_q || out_free;
	assign issue    = head_valid && s1_free;
	assign pop      = issue && step_last;

	assign idx_a  = pixel_index(head_job.data, pixel_shift(k_q, 1'b0, cfg), cfg.depth_code);
	assign idx_b  = pixel_index(head_job.data, pixel_shift(k_q, 1'b1, cfg), cfg.depth_code);
	assign addr_a = is_rd ? head_job.pidx : idx_a[7:1];
	assign addr_b = idx_b[7:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			k_q <= '0;
		else if (issue)
			k_q <= step_last ? 4'd0 : k_q + 4'd1;
	end

	// palette: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (issue && is_wr)
			pal_mem[head_job.pidx] <= head_job.data;
		if (issue && !is_wr) begin
			rdata_a_s1 <= pal_mem[addr_a];
			rdata_b_s1 <= pal_mem[addr_b];
			vld_a_s1   <= pal_vld_q[addr_a];
			vld_b_s1   <= pal_vld_q[addr_b];
			half_a_s1  <= idx_a[0];
			half_b_s1  <= idx_b[0];
			is_rd_s1   <= is_rd;
			row_s1     <= head_job.row;
			col_s1     <= head_job.col_base + 8'(k_q);
			last_s1    <= step_last;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pal_vld_q <= '0;
		else if (issue && is_wr)
			pal_vld_q[head_job.pidx] <= 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				s1_valid_q <= issue && !is_wr;
			if (out_free)
				out_valid_q <= s1_valid_q;
		end
	end

	assign entry_a = !vld_a_s1 ? 16'h0 : (half_a_s1 ? rdata_a_s1[31:16] : rdata_a_s1[15:0]);
	assign entry_b = !vld_b_s1 ? 16'h0 : (half_b_s1 ? rdata_b_s1[31:16] : rdata_b_s1[15:0]);

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q) begin
			last_s2 <= last_s1;
			if (is_rd_s1) begin
				pixel_pair_s2  <= 8'h0;
				row_index_s2   <= 8'h0;
				byte_column_s2 <= 8'h0;
				read_data_s2   <= vld_a_s1 ? rdata_a_s1 : 32'h0;
			end else begin
				pixel_pair_s2  <= {grey_of(entry_a, cfg.grey_from_high_bits),
					grey_of(entry_b, cfg.grey_from_high_bits)};
				row_index_s2   <= row_s1;
				byte_column_s2 <= col_s1;
				read_data_s2   <= 32'h0;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.pixel_pair  = pixel_pair_s2;
	assign res.row_index   = row_index_s2;
	assign res.byte_column = byte_column_s2;
	assign res.read_data   = read_data_s2;
	assign res.last        = last_s2;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import lcdpu_pkg::*;

	localparam int ROWS       = 240;
	localparam int COLUMNS    = 320;
	localparam int MAX_CYCLES = 400000;
	localparam int IDLE_PCT   = 18;
	localparam int SHOW_MAX   = 40;
	localparam int ROW_CROSS_WORDS = COLUMNS / 32 + 2;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	// {depth_code, grey_from_high_bits, big_endian_bytes, msb_pixel_first}
	localparam logic [39:0] MODE_LIST = {5'b00000, 5'b11111, 5'b01010, 5'b10101,
		5'b11000, 5'b00111, 5'b01100, 5'b10011};

	typedef struct {
		kind_t       kind;
		logic [6:0]  widx;
		logic [31:0] data;
	} lcd_req_t;

	typedef struct {
		logic [7:0]  pair;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [31:0] rdata;
		logic        last;
	} lcd_out_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [1:0] cfg_wdata;

	lcdpu_cmd_if cmd();
	lcdpu_res_if res();

	palette_lcd_pixel_unpacker_top #(.ROWS(ROWS), .COLUMNS(COLUMNS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	lcd_req_t    send_q[$];
	lcd_out_t    lcd_out_due[$];
	logic [15:0] pal_mem [PAL_DEPTH];
	int unsigned row_now;
	int unsigned word_now;
	logic [1:0]  mode_depth;
	logic        mode_grey_hi;
	logic        mode_big;
	logic        mode_msb;
	int          errors;
	int          cycles;
	bit          calm;
	bit          cmd_fired;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// expected bytes of one accepted request; also advances row/column state
	function automatic void unpack_request(lcd_req_t r);
		int unsigned bpp, pmask, gshift, order, nbytes, wpr, bitpos, idx1, idx2, k;
		lcd_out_t o;
		o = '{8'd0, 8'd0, 8'd0, 32'd0, 1'b1};
		case (r.kind)
			KIND_FRAME: begin
				row_now = ROWS - 1;
				word_now = 0;
			end
			KIND_PAL_WR: begin
				pal_mem[2 * r.widx] = r.data[15:0];
				pal_mem[2 * r.widx + 1] = r.data[31:16];
			end
			KIND_PAL_RD: begin
				o.rdata = {pal_mem[2 * r.widx + 1], pal_mem[2 * r.widx]};
				lcd_out_due.push_back(o);
			end
			default: begin
				bpp = 1 << mode_depth;
				pmask = (1 << bpp) - 1;
				gshift = mode_grey_hi ? 11 : 1;
				order = mode_big ? 0 : 24;
				if (!mode_msb)
					order = order ^ (8 - bpp);
				nbytes = 16 / bpp;
				wpr = (COLUMNS / 32) * bpp;
				bitpos = 32;
				for (k = 0; k < nbytes; k++) begin
					bitpos -= bpp;
					idx1 = (r.data >> ((bitpos ^ order) & 31)) & pmask;
					bitpos -= bpp;
					idx2 = (r.data >> ((bitpos ^ order) & 31)) & pmask;
					o.pair = {4'(pal_mem[idx1] >> gshift), 4'(pal_mem[idx2] >> gshift)};
					o.row = 8'(row_now);
					o.col = 8'(word_now * nbytes + k);
					o.rdata = 32'd0;
					o.last = (k + 1 == nbytes);
					lcd_out_due.push_back(o);
				end
				if (word_now + 1 >= wpr) begin
					word_now = 0;
					row_now = (row_now == 0) ? ROWS - 1 : row_now - 1;
				end else begin
					word_now++;
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= SHOW_MAX)
			$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
	endtask

	task automatic check_output();
		lcd_out_t want;
		if (lcd_out_due.size() == 0) begin
			report_mismatch("result with none expected", res.pixel_pair, 0);
			return;
		end
		want = lcd_out_due.pop_front();
		if (res.pixel_pair !== want.pair)
			report_mismatch("pixel_pair", res.pixel_pair, want.pair);
		if (res.row_index !== want.row)
			report_mismatch("row_index", res.row_index, want.row);
		if (res.byte_column !== want.col)
			report_mismatch("byte_column", res.byte_column, want.col);
		if (res.read_data !== want.rdata)
			report_mismatch("read_data", res.read_data, want.rdata);
		if (res.last !== want.last)
			report_mismatch("last", res.last, want.last);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (arst_n) begin
			if (cmd.valid && cmd.ready) begin
				unpack_request('{kind_t'(cmd.kind), cmd.palette_word_index, cmd.data_word});
				void'(send_q.pop_front());
				cmd_fired = 1'b1;
			end
			if (res.valid && res.ready)
				check_output();
		end
	end

	always @(posedge clk) begin
		if (cycles > MAX_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!cmd.valid || cmd_fired) begin
				cmd_fired = 1'b0;
				if (send_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					cmd.valid <= 1'b1;
					cmd.kind <= send_q[0].kind;
					cmd.palette_word_index <= send_q[0].widx;
					cmd.data_word <= send_q[0].data;
				end else begin
					cmd.valid <= 1'b0;
				end
			end
			res.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic push_req(kind_t kind, logic [6:0] widx, logic [31:0] data);
		send_q.push_back('{kind, widx, data});
	endtask

	task automatic push_random();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 6)
			push_req(KIND_FRAME, 7'($urandom), $urandom);
		else if (pick < 18)
			push_req(KIND_PAL_WR, 7'($urandom), $urandom);
		else if (pick < 28)
			push_req(KIND_PAL_RD, 7'($urandom), $urandom);
		else
			push_req(KIND_PIXEL, 7'($urandom), $urandom);
	endtask

	task automatic wait_drained(int settle);
		while (send_q.size() != 0 || lcd_out_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// upper data bit of the one-bit registers is don't-care, so it is randomized
	task automatic set_mode(logic [4:0] code);
		wait_drained(12);
		mode_depth = code[4:3];
		mode_grey_hi = code[2];
		mode_big = code[1];
		mode_msb = code[0];
		write_reg(REG_DEPTH_CODE, code[4:3]);
		write_reg(REG_GREY_HIGH, {1'($urandom), code[2]});
		write_reg(REG_BIG_ENDIAN, {1'($urandom), code[1]});
		write_reg(REG_MSB_FIRST, {1'($urandom), code[0]});
	endtask

	initial begin
		int i;
		int p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEPTH_CODE;
		cfg_wdata = 2'd0;
		cmd.valid = 1'b0;
		cmd.kind = KIND_FRAME;
		cmd.palette_word_index = 7'd0;
		cmd.data_word = 32'd0;
		res.ready = 1'b0;
		errors = 0;
		cycles = 0;
		calm = 1'b0;
		cmd_fired = 1'b0;
		for (i = 0; i < PAL_DEPTH; i++)
			pal_mem[i] = 16'd0;
		row_now = ROWS - 1;
		word_now = 0;
		mode_depth = 2'd0;
		mode_grey_hi = 1'b0;
		mode_big = 1'b0;
		mode_msb = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// no such register: must leave the reset settings alone
		write_reg(REG_UNUSED, 2'b11);

		// directed, reset settings (1 bpp, low grey bits, little endian, reversed pixels)
		push_req(KIND_PAL_RD, 7'd0, 32'd0);
		push_req(KIND_PAL_WR, 7'd0, 32'hFFFF_0000);
		push_req(KIND_PAL_RD, 7'd0, 32'hFFFF_FFFF);
		push_req(KIND_PAL_WR, 7'd127, 32'hFFFF_FFFF);
		push_req(KIND_PAL_RD, 7'd127, 32'd0);
		push_req(KIND_PAL_WR, 7'd1, 32'h1234_ABCD);
		for (i = 2; i < 8; i++)
			push_req(KIND_PAL_WR, 7'(i), $urandom);
		push_req(KIND_PAL_RD, 7'd1, 32'd0);
		push_req(KIND_FRAME, 7'd127, 32'hFFFF_FFFF);
		push_req(KIND_PIXEL, 7'd0, 32'h0000_0000);
		push_req(KIND_PIXEL, 7'd127, 32'hFFFF_FFFF);
		push_req(KIND_PIXEL, 7'd0, 32'h8000_0001);
		push_req(KIND_PIXEL, 7'($urandom), $urandom);
		push_req(KIND_FRAME, 7'd0, 32'd0);
		push_req(KIND_PIXEL, 7'($urandom), $urandom);

		// spread entries over the whole palette for 8 bpp lookups
		for (i = 0; i < 10; i++)
			push_req(KIND_PAL_WR, 7'($urandom), $urandom);

		// deep into a row at 8 bpp, then drop to 1 bpp: column wraps, row ends
		set_mode(5'b11111);
		push_req(KIND_FRAME, 7'($urandom), $urandom);
		for (i = 0; i < 17; i++)
			push_req(KIND_PIXEL, 7'($urandom), $urandom);
		set_mode(5'b00000);
		push_req(KIND_PIXEL, 7'($urandom), $urandom);
		push_req(KIND_PIXEL, 7'($urandom), $urandom);

		for (p = 0; p < 8; p++) begin
			set_mode(MODE_LIST[p * 5 +: 5]);
			for (i = 0; i < 4; i++) begin
				if (p == 2 && i == 2)
					wait_drained(0);
				push_random();
			end
		end

		// across a row end, with no idling on either side
		set_mode({2'd0, 3'($urandom)});
		calm = 1'b1;
		push_req(KIND_FRAME, 7'($urandom), $urandom);
		for (i = 0; i < ROW_CROSS_WORDS; i++)
			push_req(KIND_PIXEL, 7'($urandom), $urandom);
		wait_drained(0);
		calm = 1'b0;

		for (i = 0; i < 5; i++)
			push_random();

		wait_drained(20);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/lcdpu_pkg.sv
rtl/core/lcdpu_if.sv
rtl/core/lcdpu_front.sv
rtl/core/lcdpu_queue.sv
rtl/core/lcdpu_back.sv
rtl/core/palette_lcd_pixel_unpacker_top.sv
tb/tb_top.sv
